/* src/hsv_to_rgb_macros.svh */
// Assertion macros used by the hsv_to_rgb top module.
`ifndef HSV_TO_RGB_MACROS_SVH
`define HSV_TO_RGB_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define HSV_ASSERT_IMPL(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("hsv_to_rgb assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define HSV_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("hsv_to_rgb assertion failed");

`else

`define HSV_ASSERT_IMPL(lbl, clk_s, rst_s, pre, post)
`define HSV_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post)

`endif

`endif

/* src/hsv_pkg.sv */
`default_nettype none

package hsv_pkg;

    // Field widths.
    localparam int HUE_W = 13;
    localparam int CH_W  = 8;
    localparam int T_W   = 10;
    localparam int NUM_W = 26;

    // Hue geometry in 1/16 degree units.
    localparam int HUE_PER_SECTOR = 960;
    localparam int HUE_LIMIT      = 5760;

    // Byte scale and its reciprocal: floor(x / 255) = (x * 257) >> 16, then one fix-up.
    localparam int BYTE_MAX   = 255;
    localparam int BYTE_RECIP = 257;
    localparam int BYTE_SHIFT = 16;

    // Secondary channel divisor 960 * 255 and its truncated reciprocal at 2^32.
    localparam int X_DIV     = HUE_PER_SECTOR * BYTE_MAX;
    localparam int X_SHIFT   = 32;
    localparam int X_RECIP   = 17544;
    localparam int X_RECIP_W = 15;
    localparam int X_PROD_W  = NUM_W + X_RECIP_W;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Hue sector, named by the hue range it spans.
    typedef enum logic [2:0] {
        SEC_R_TO_Y,
        SEC_Y_TO_G,
        SEC_G_TO_C,
        SEC_C_TO_B,
        SEC_B_TO_M,
        SEC_M_TO_R
    } sector_t;

    // Input color.
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    // Result color.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            hue_error;
    } rgb_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic            err;
        sector_t         sector;
        logic [T_W-1:0]  t;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
    } work_t;

    // Queue status flags.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

/* src/hsv_to_rgb.sv */
// hsv_to_rgb: converts one HSV color to 8-bit RGB by the six-sector hue rule.
// Input channel: a queue-style write port. Present the color on the color port
// and raise push; the color is transferred at a rising edge where push is high
// and full is low. Hue is in 1/16 degree units, saturation and brightness are
// bytes meaning n/255.
// Result channel: a queue-style read port. While empty is low the oldest result
// is on the result port; it is transferred at a rising edge where pop is high.
// A hue of 360 degrees or more gives hue_error set and all channels zero.
// A color passes through the queue, then the stage 1, 2 and 3 registers and the output
// register. Throughput: one color per cycle while the receiver keeps up, set by the
// four-stage multiply and reciprocal pipeline of the back end, which takes one item a cycle.
// A short queue sits between the classifying front end and that pipeline.
// When the receiver stalls, the pipeline holds its contents, the queue fills,
// and full rises once the queue is full; nothing is dropped.
// Reset clears the queue and all valid bits; the block comes up empty, not full.
`default_nettype none

`include "hsv_to_rgb_macros.svh"

module hsv_to_rgb #(
    parameter int QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    output logic          full,
    input  hsv_pkg::hsv_t color,
    output logic          empty,
    input  wire           pop,
    output hsv_pkg::rgb_t result
);
    import hsv_pkg::*;

    work_t       front_work;
    work_t       head_work;
    queue_stat_t q_stat;
    logic        back_take;
    logic        back_valid;

    // Front end: sector, ramp position and range check.
    hsv_front u_front (
        .color (color),
        .work  (front_work)
    );

    // Queue between front and back.
    hsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (front_work),
        .rd      (back_take),
        .rd_data (head_work),
        .status  (q_stat)
    );

    // Back end: arithmetic pipeline and output register.
    hsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_stat.empty),
        .work      (head_work),
        .take      (back_take),
        .pop       (pop),
        .out_valid (back_valid),
        .result    (result)
    );

    assign full  = q_stat.full;
    assign empty = !back_valid;

    // An accepted color is in the queue in the next cycle.
    `HSV_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full, !q_stat.empty)
    // An error result carries black.
    `HSV_ASSERT_IMPL(a_err_black, clk, rst_n, !empty && result.hue_error,
                     result.red == '0 && result.green == '0 && result.blue == '0)
    // The queue status flags never both hold.
    `HSV_ASSERT_IMPL(a_queue_flags, clk, rst_n, q_stat.full, !q_stat.empty)

endmodule

`default_nettype wire

/* src/hsv_front.sv */
`default_nettype none

module hsv_front (
    input  hsv_pkg::hsv_t  color,
    output hsv_pkg::work_t work
);
    import hsv_pkg::*;

    sector_t          sector;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] offset;
    logic             falling;
    logic [T_W-1:0]   t;

    // Find the sector by comparing against the sector boundaries.
    always_comb
    begin
        if (color.hue < HUE_W'(HUE_PER_SECTOR))
            sector = SEC_R_TO_Y;
        else if (color.hue < HUE_W'(2 * HUE_PER_SECTOR))
            sector = SEC_Y_TO_G;
        else if (color.hue < HUE_W'(3 * HUE_PER_SECTOR))
            sector = SEC_G_TO_C;
        else if (color.hue < HUE_W'(4 * HUE_PER_SECTOR))
            sector = SEC_C_TO_B;
        else if (color.hue < HUE_W'(5 * HUE_PER_SECTOR))
            sector = SEC_B_TO_M;
        else
            sector = SEC_M_TO_R;
    end

    // Start of the sector and the direction of the secondary ramp.
    always_comb
    begin
        unique case (sector)
            SEC_R_TO_Y: base = HUE_W'(0);
            SEC_Y_TO_G: base = HUE_W'(HUE_PER_SECTOR);
            SEC_G_TO_C: base = HUE_W'(2 * HUE_PER_SECTOR);
            SEC_C_TO_B: base = HUE_W'(3 * HUE_PER_SECTOR);
            SEC_B_TO_M: base = HUE_W'(4 * HUE_PER_SECTOR);
            default:    base = HUE_W'(5 * HUE_PER_SECTOR);
        endcase
        case (sector) inside
            SEC_Y_TO_G, SEC_C_TO_B, SEC_M_TO_R: falling = 1'b1;
            default:                            falling = 1'b0;
        endcase
    end

    // Ramp position within the sector: rising in even sectors, falling in odd ones.
    assign offset = color.hue - base;
    assign t      = falling ? T_W'(HUE_PER_SECTOR) - offset[T_W-1:0] : offset[T_W-1:0];

    assign work.err    = (color.hue >= HUE_W'(HUE_LIMIT));
    assign work.sector = sector;
    assign work.t      = t;
    assign work.sat    = color.saturation;
    assign work.val    = color.brightness;

endmodule

`default_nettype wire

/* src/hsv_queue.sv */
`default_nettype none

module hsv_queue #(
    parameter int DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr,
    input  hsv_pkg::work_t       wr_data,
    input  wire                  rd,
    output hsv_pkg::work_t       rd_data,
    output hsv_pkg::queue_stat_t status
);
    import hsv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Pointer and occupancy updates, with wrap at the last entry.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* src/hsv_back.sv */
`default_nettype none

module hsv_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    input  hsv_pkg::work_t work,
    output logic           take,
    input  wire            pop,
    output logic           out_valid,
    output hsv_pkg::rgb_t  result
);
    import hsv_pkg::*;

    logic adv;

    // Stage 1 registers: saturation times value, and value times (255 - saturation).
    logic            s1_valid_reg;
    logic            s1_err_reg;
    sector_t         s1_sector_reg;
    logic [T_W-1:0]  s1_t_reg;
    logic [CH_W-1:0] s1_val_reg;
    logic [15:0]     s1_sv_reg;
    logic [15:0]     s1_vns_reg;

    // Stage 2 registers: secondary numerator and the byte reciprocal product.
    logic            s2_valid_reg;
    logic            s2_err_reg;
    sector_t         s2_sector_reg;
    logic [CH_W-1:0] s2_val_reg;
    logic [NUM_W-1:0] s2_num_reg;
    logic [24:0]     s2_p0prod_reg;
    logic [15:0]     s2_vns_reg;

    // Stage 3 registers: estimated secondary quotient and the floor channel.
    logic            s3_valid_reg;
    logic            s3_err_reg;
    sector_t         s3_sector_reg;
    logic [CH_W-1:0] s3_val_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic [CH_W-1:0] s3_qx_reg;
    logic [CH_W-1:0] s3_p0_reg;

    // Output register.
    logic            out_valid_reg;
    rgb_t            result_reg, result_next;

    logic [CH_W-1:0]     inv_sat;
    logic [15:0]         sv_c, vns_c;
    logic [NUM_W-1:0]    num_c;
    logic [24:0]         p0prod_c;
    logic [X_PROD_W-1:0] xprod_c;
    logic [CH_W-1:0]     p0q_c, p0_c;
    logic [15:0]         p0rem_c;
    logic [NUM_W-1:0]    xrem_c;
    logic [CH_W-1:0]     px_c, pc_c;

    // The whole pipeline moves while the output register is free or being drained.
    assign adv  = !out_valid_reg || pop;
    assign take = adv && in_valid;

    // Stage 1 products.
    assign inv_sat = CH_W'(BYTE_MAX) - work.sat;
    assign sv_c    = 16'(work.sat) * 16'(work.val);
    assign vns_c   = 16'(work.val) * 16'(inv_sat);

    // Stage 2: S*V*t + 960*V*(255-S), and V*(255-S)*257 for the floor channel.
    assign num_c    = NUM_W'(s1_sv_reg) * NUM_W'(s1_t_reg)
                    + NUM_W'(s1_vns_reg) * NUM_W'(HUE_PER_SECTOR);
    assign p0prod_c = 25'(s1_vns_reg) * 25'(BYTE_RECIP);

    // Stage 3: reciprocal estimate of the secondary quotient; fix up the floor channel.
    assign xprod_c = X_PROD_W'(s2_num_reg) * X_PROD_W'(X_RECIP);
    assign p0q_c   = s2_p0prod_reg[BYTE_SHIFT +: CH_W];
    assign p0rem_c = s2_vns_reg - 16'(p0q_c) * 16'(BYTE_MAX);
    assign p0_c    = (p0rem_c >= 16'(BYTE_MAX)) ? p0q_c + 1'b1 : p0q_c;

    // Stage 4: the estimate is low by at most one; correct it by the remainder.
    assign xrem_c = s3_num_reg - NUM_W'(s3_qx_reg) * NUM_W'(X_DIV);
    assign px_c   = (xrem_c >= NUM_W'(X_DIV)) ? s3_qx_reg + 1'b1 : s3_qx_reg;
    assign pc_c   = s3_val_reg;

    // Route the three levels to the channels by sector.
    always_comb
    begin
        result_next.hue_error = 1'b0;
        unique case (s3_sector_reg)
            SEC_R_TO_Y:
            begin
                result_next.red = pc_c; result_next.green = px_c; result_next.blue = s3_p0_reg;
            end
            SEC_Y_TO_G:
            begin
                result_next.red = px_c; result_next.green = pc_c; result_next.blue = s3_p0_reg;
            end
            SEC_G_TO_C:
            begin
                result_next.red = s3_p0_reg; result_next.green = pc_c; result_next.blue = px_c;
            end
            SEC_C_TO_B:
            begin
                result_next.red = s3_p0_reg; result_next.green = px_c; result_next.blue = pc_c;
            end
            SEC_B_TO_M:
            begin
                result_next.red = px_c; result_next.green = s3_p0_reg; result_next.blue = pc_c;
            end
            default:
            begin
                result_next.red = pc_c; result_next.green = s3_p0_reg; result_next.blue = px_c;
            end
        endcase
        if (s3_err_reg)
        begin
            result_next.red       = '0;
            result_next.green     = '0;
            result_next.blue      = '0;
            result_next.hue_error = 1'b1;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads advance together with the valid bits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg    <= work.err;
            s1_sector_reg <= work.sector;
            s1_t_reg      <= work.t;
            s1_val_reg    <= work.val;
            s1_sv_reg     <= sv_c;
            s1_vns_reg    <= vns_c;

            s2_err_reg    <= s1_err_reg;
            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
            s2_num_reg    <= num_c;
            s2_p0prod_reg <= p0prod_c;
            s2_vns_reg    <= s1_vns_reg;

            s3_err_reg    <= s2_err_reg;
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_num_reg    <= s2_num_reg;
            s3_qx_reg     <= xprod_c[X_SHIFT +: CH_W];
            s3_p0_reg     <= p0_c;

            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire
